[rtl/core/sida_pkg.sv]
package sida_pkg;

  // operand and digit geometry
  localparam int unsigned BITS   = 32;
  localparam int unsigned DIGITS = 10;
  localparam int unsigned CNT_W  = $clog2(BITS);
  localparam int unsigned IDX_W  = $clog2(DIGITS);
  localparam int unsigned CHAR_W = 6;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_EMIT
  } sida_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic find;
    logic emit_sign;
    logic emit_digit;
  } sida_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;
    logic neg;
    logic idx_zero;
    logic out_free;
  } sida_status_t;

endpackage

[rtl/core/sida_ctrl.sv]
module sida_ctrl
  import sida_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  sida_status_t status,
  output sida_cmd_t    cmd
);

  sida_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (status.conv_done) state_nxt = ST_FIND;
      end
      ST_FIND: begin
        state_nxt = status.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (status.out_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.idx_zero) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
      end
      ST_FIND: begin
        cmd.find = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit_sign = status.out_free;
      end
      ST_EMIT: begin
        cmd.emit_digit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/core/sida_dp.sv]
module sida_dp
  import sida_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [BITS-1:0] in_value,
  input  sida_cmd_t          cmd,
  output sida_status_t       status,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [CHAR_W-1:0]  out_char_code,
  output logic               out_last_char
);

  logic [BITS-1:0]              mag_r;
  logic [DIGITS-1:0][3:0]       bcd_r;
  logic                         neg_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [IDX_W-1:0]             idx_r;
  logic                         out_valid_r;
  logic [CHAR_W-1:0]            out_char_r;
  logic                         out_last_r;

  logic [DIGITS-1:0][3:0]       bcd_adj;
  logic [4*DIGITS:0]            shifted;
  logic [IDX_W-1:0]             msd;
  logic [3:0]                   cur_digit;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      bcd_adj[d] = (bcd_r[d] >= 4'd5) ? bcd_r[d] + 4'd3 : bcd_r[d];
    end
  end

  assign shifted = {bcd_adj, mag_r[BITS-1]};

  // most significant nonzero digit, units digit when all are zero
  always_comb begin
    msd = '0;
    for (int d = 1; d < DIGITS; d++) begin
      if (bcd_r[d] != 4'd0) msd = IDX_W'(d);
    end
  end

  assign cur_digit = bcd_r[idx_r];

  // conversion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.shift) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.find) begin
        idx_r <= msd;
      end else if (cmd.emit_digit && idx_r != '0) begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  // magnitude and digit shifter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_value[BITS-1];
      mag_r <= in_value[BITS-1] ? (~in_value + 1'b1) : in_value;
      bcd_r <= '0;
    end else if (cmd.shift) begin
      mag_r <= {mag_r[BITS-2:0], 1'b0};
      bcd_r <= shifted[4*DIGITS-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= CHAR_ZERO + {2'b00, cur_digit};
      out_last_r <= (idx_r == '0);
    end
  end

  assign status.conv_done = (cnt_r == CNT_W'(BITS - 1));
  assign status.neg       = neg_r;
  assign status.idx_zero  = (idx_r == '0);
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

endmodule

[rtl/core/signed_int_to_decimal_ascii_top.sv]
// from an accepted request: one load, then 32 shift-and-adjust steps of the digit converter,
// then one digit search, before the sign or first digit enters the output register
// a request's text (1 to 11 characters) is fully handed to the output register before the next is taken;
// a new request is taken while the final character still waits in the output register
// reset: synchronous active-low rst_n clears the controller, the converter counters and the output valid
module signed_int_to_decimal_ascii_top
  import sida_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [BITS-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAR_W-1:0]      out_char_code,
  output logic                   out_last_char
);

  sida_cmd_t    cmd;
  sida_status_t status;

  // sequencer
  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // converter and output register
  sida_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .status        (status),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

[rtl/core/sida_checker.sv]
module sida_checker
  import sida_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [CHAR_W-1:0]      out_char_code,
  input logic                   out_last_char
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("stalled character changed");

  // the block is busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while converting");

  // only minus or a digit leaves the block
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_code == CHAR_MINUS ||
                  (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_ZERO + 6'd9))
    else $error("illegal character code");

  // a minus sign never ends the text
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char_code (out_char_code),
  .out_last_char (out_last_char)
);

[test/tb_signed_int_to_decimal_ascii_top.sv]
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_top;
  import sida_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [BITS-1:0] in_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [CHAR_W-1:0]      out_char_code;
  logic                   out_last_char;

  // characters still owed by the block, oldest first
  text_char_t pending_chars[$];
  int         err_count;
  bit         tx_idle_on;
  logic       rx_idle_on;
  logic       rx_hold;

  signed_int_to_decimal_ascii_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // decimal text of one value, queued as owed characters
  function automatic void queue_decimal_text(input logic [BITS-1:0] value);
    logic            neg;
    logic [BITS-1:0] mag;
    logic [BITS-1:0] rem;
    logic [3:0]      dig[DIGITS];
    int              n_dig;
    text_char_t      ch;
    neg = value[BITS-1];
    mag = neg ? (~value + 1'b1) : value;
    rem = mag;
    for (int i = 0; i < DIGITS; i++) begin
      dig[i] = 4'(rem % 10);
      rem    = rem / 10;
    end
    n_dig = 1;
    for (int i = DIGITS - 1; i > 0; i--) begin
      if (dig[i] != 4'd0) begin
        n_dig = i + 1;
        break;
      end
    end
    if (neg) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
    end
    for (int i = n_dig - 1; i >= 0; i--) begin
      ch.code = CHAR_ZERO + CHAR_W'(dig[i]);
      ch.last = (i == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  // offer one request, after a random gap when sender idling is on; leave valid high after it is taken
  task automatic send_value(input logic [BITS-1:0] value);
    int gap;
    bit taken;
    gap = 0;
    if (tx_idle_on) begin
      while ($urandom_range(0, 99) < 23) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    queue_decimal_text(value);
  endtask

  // drop valid and wait for every owed character
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_chars.size() == 0);
    @(posedge clk);
  endtask

  // value with a random number of decimal digits and a random sign
  function automatic logic [BITS-1:0] random_value();
    logic [BITS-1:0] v;
    logic [BITS-1:0] pow;
    int              k;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 999);
      2: begin
        k   = $urandom_range(0, 9);
        pow = 1;
        repeat (k) pow = pow * 10;
        v   = pow + $urandom_range(0, 2) - 1;
      end
      default: begin
        k   = $urandom_range(1, 9);
        pow = 1;
        repeat (k) pow = pow * 10;
        v   = $urandom % pow;
      end
    endcase
    if ($urandom_range(0, 1)) v = ~v + 1'b1;
    return v;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_on && ($urandom_range(0, 99) < 23);
    end
  end

  // compare each accepted character with the oldest owed one
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: char_code %0d last_char %0d",
               out_char_code, out_last_char);
        err_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code mismatch: expected %0d, actual %0d", want.code, out_char_code);
          err_count++;
        end
        if (out_last_char !== want.last) begin
          $error("last_char mismatch: expected %0d, actual %0d", want.last, out_last_char);
          err_count++;
        end
      end
    end
  end

  task automatic test_reset();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_value   <= '0;
    rx_idle_on <= 1'b1;
    rx_hold    <= 1'b0;
    tx_idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // field extremes, zero, most negative value, digit count boundaries
  task automatic test_directed();
    logic [BITS-1:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0001, 32'd99, 32'd100, 32'd999_999_999,
             32'd1_000_000_000, -32'sd999_999_999, -32'sd1_000_000_000,
             32'd123_456_789, 32'h5555_5555, 32'haaaa_aaaa, 32'd2_000_000_000,
             -32'sd9};
    foreach (vals[i]) send_value(vals[i]);
    drain_results();
  endtask

  // long stretch with no idling on either side
  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    repeat (30) send_value(random_value());
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (600) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        repeat (12) send_value(random_value());
      end
    join
    drain_results();
    tx_idle_on = 1'b1;
  endtask

  // random values with idling on both sides
  task automatic test_random();
    for (int i = 0; i < 88; i++) begin
      send_value(random_value());
      if ($urandom_range(0, 39) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    err_count = 0;
    test_reset();
    test_directed();
    test_back_to_back();
    test_backpressure();
    test_random();
    // allow for stray characters after the last owed one
    repeat (100) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("characters never delivered: %0d", pending_chars.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
